// ===== src/sobsq_pkg.sv =====
// ----------------------------------------------------------------------------
// sobsq_pkg
// Shared types and constants for the Sobel squared-magnitude pipeline.
// ----------------------------------------------------------------------------
package sobsq_pkg;

  // Line geometry
  localparam int MAX_WIDTH = 1024;
  localparam int MIN_WIDTH = 3;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 11;

  // Data widths
  localparam int PIX_W  = 8;
  localparam int GRAD_W = 10;
  localparam int SQ_W   = 2 * GRAD_W;
  localparam int MAG_W  = 21;

  localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = WIDTH_W'(640);

  // Input beat
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             start_of_frame;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [MAG_W-1:0] magnitude_sq;
    logic [MAG_W-1:0] frame_max;
  } out_beat_t;

  // Two stored rows at one column: older (top) and newer (mid)
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
  } lines_t;

  // Per-pixel control decided at accept time
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             sof;
    logic             has_result;
  } ctrl_t;

  // Control carried down the later stages
  typedef struct packed {
    logic sof;
    logic has_result;
  } flag_t;

endpackage

// ===== src/sobel_gradient_squared_magnitude_top.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_squared_magnitude_top
// Streaming 3x3 Sobel edge detector giving squared gradient magnitude and
// the running frame maximum.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while in_stall is low, and gives
// one result beat per interior pixel. The rate is set by the line buffer
// memory, which does one read and one write each cycle (rows of up to 1024
// pixels, both rows in one memory). The pipeline runs line buffer read,
// window and gradients, squares, then sum, maximum and result register;
// empty stages close up, so a stalled result only holds the input once all
// four stages are full. start_of_frame on a pixel restarts the row and
// column position and clears the maximum. The line buffers need no
// initialization: results are flagged only from the third row on, once
// both rows above have been written. Write line_width only while the block
// is idle; it applies from the next pixel, clamped to 3..1024.
// ----------------------------------------------------------------------------
module sobel_gradient_squared_magnitude_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sobsq_pkg::in_beat_t            in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sobsq_pkg::out_beat_t           out_data,
  input  logic                           cfg_wr_en,
  input  logic [sobsq_pkg::WIDTH_W-1:0]  cfg_wr_data
);

  logic [sobsq_pkg::WIDTH_W-1:0] line_width_r;
  logic                          accept;
  logic                          en1, en2, en3, en_out;
  logic                          s1_go, s2_go, s3_go;
  logic                          s1_v_r, s2_v_r, s3_v_r;
  sobsq_pkg::ctrl_t              ctrl, s1_ctrl_r;
  sobsq_pkg::flag_t              s2_flags_r, s3_flags_r;
  logic [sobsq_pkg::PIX_W-1:0]   s1_pix_r;
  sobsq_pkg::lines_t             s1_lines, wr_lines;
  logic [sobsq_pkg::GRAD_W-1:0]  gx, gy;

  // Width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= sobsq_pkg::LINE_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      line_width_r <= cfg_wr_data;
    end
  end

  // Stage enables; a stage moves when it is empty or the next one moves
  assign en_out   = !out_valid || !out_stall;
  assign en3      = !s3_v_r || en_out;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign s3_go    = s3_v_r && en_out;
  assign s2_go    = s2_v_r && en3;
  assign s1_go    = s1_v_r && en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_r <= in_valid;
      end
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl_r <= ctrl;
      s1_pix_r  <= in_data.pixel;
    end
    if (s1_go) begin
      s2_flags_r.sof        <= s1_ctrl_r.sof;
      s2_flags_r.has_result <= s1_ctrl_r.has_result;
    end
    if (s2_go) begin
      s3_flags_r <= s2_flags_r;
    end
  end

  sobsq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sof        (in_data.start_of_frame),
    .line_width (line_width_r),
    .ctrl       (ctrl)
  );

  // Rows move up by one: newer row becomes older, incoming pixel the newer
  assign wr_lines.top = s1_lines.mid;
  assign wr_lines.mid = s1_pix_r;

  sobsq_linebuf u_linebuf (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_ctrl_r.col),
    .wr_data (wr_lines),
    .rd_en   (accept),
    .rd_addr (ctrl.col),
    .rd_data (s1_lines)
  );

  sobsq_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .shift (s1_go),
    .lines (s1_lines),
    .pixel (s1_pix_r),
    .gx    (gx),
    .gy    (gy)
  );

  sobsq_mag u_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_sq   (s2_go),
    .gx        (gx),
    .gy        (gy),
    .load_out  (s3_go),
    .flags     (s3_flags_r),
    .out_ready (!out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Input is held back only when every stage is occupied and the result stalls
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r && out_valid && out_stall))
    else $error("input stalled with an empty pipeline stage");

  // An interior pixel leaving the last stage always shows a result beat
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_go && s3_flags_r.has_result) |=> out_valid)
    else $error("result beat lost at output register");

  // Frame maximum covers the current magnitude
  a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frame_max >= out_data.magnitude_sq))
    else $error("frame maximum below current magnitude");

endmodule

// ===== src/sobsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sobsq_ctrl
// Column and row tracking; gives the line buffer column and result flag of
// the pixel being accepted.
// ----------------------------------------------------------------------------
module sobsq_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic                           sof,
  input  logic [sobsq_pkg::WIDTH_W-1:0]  line_width,
  output sobsq_pkg::ctrl_t               ctrl
);

  logic [sobsq_pkg::COL_W-1:0]   col_r, col_nxt, col_cur;
  logic [1:0]                    rows_r, rows_nxt, rows_cur;
  logic [sobsq_pkg::WIDTH_W-1:0] width_eff;
  logic                          last_col;

  // Clamp configured width to the supported range
  always_comb begin
    if (line_width < sobsq_pkg::WIDTH_W'(sobsq_pkg::MIN_WIDTH)) begin
      width_eff = sobsq_pkg::WIDTH_W'(sobsq_pkg::MIN_WIDTH);
    end else if (line_width > sobsq_pkg::WIDTH_W'(sobsq_pkg::MAX_WIDTH)) begin
      width_eff = sobsq_pkg::WIDTH_W'(sobsq_pkg::MAX_WIDTH);
    end else begin
      width_eff = line_width;
    end
  end

  // Start of frame restarts position before this pixel is placed
  assign col_cur  = sof ? '0 : col_r;
  assign rows_cur = sof ? 2'd0 : rows_r;
  assign last_col = (sobsq_pkg::WIDTH_W'(col_cur) + sobsq_pkg::WIDTH_W'(1)) >= width_eff;

  assign ctrl.col        = col_cur;
  assign ctrl.sof        = sof;
  assign ctrl.has_result = rows_cur[1] && (col_cur >= sobsq_pkg::COL_W'(2));

  // Next position; rows saturate at two
  always_comb begin
    col_nxt  = col_cur + sobsq_pkg::COL_W'(1);
    rows_nxt = rows_cur;
    if (last_col) begin
      col_nxt = '0;
      if (!rows_cur[1]) begin
        rows_nxt = rows_cur + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      rows_r <= 2'd0;
    end else if (accept) begin
      col_r  <= col_nxt;
      rows_r <= rows_nxt;
    end
  end

endmodule

// ===== src/sobsq_linebuf.sv =====
// ----------------------------------------------------------------------------
// sobsq_linebuf
// Two line buffers packed side by side in one memory, one write and one
// registered read per cycle, with write-to-read bypass on the same column.
// ----------------------------------------------------------------------------
module sobsq_linebuf (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [sobsq_pkg::COL_W-1:0]  wr_addr,
  input  sobsq_pkg::lines_t            wr_data,
  input  logic                         rd_en,
  input  logic [sobsq_pkg::COL_W-1:0]  rd_addr,
  output sobsq_pkg::lines_t            rd_data
);

  sobsq_pkg::lines_t mem [sobsq_pkg::MAX_WIDTH];
  sobsq_pkg::lines_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a write to the same column this cycle is passed through
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/sobsq_window.sv =====
// ----------------------------------------------------------------------------
// sobsq_window
// 3x3 window columns and the Sobel gradient magnitudes |Gx| and |Gy|.
// ----------------------------------------------------------------------------
module sobsq_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift,
  input  sobsq_pkg::lines_t             lines,
  input  logic [sobsq_pkg::PIX_W-1:0]   pixel,
  output logic [sobsq_pkg::GRAD_W-1:0]  gx,
  output logic [sobsq_pkg::GRAD_W-1:0]  gy
);

  logic [sobsq_pkg::PIX_W-1:0]  lt_r, lm_r, lb_r, ct_r, cm_r, cb_r;
  logic [sobsq_pkg::GRAD_W-1:0] right, left, upper, lower;
  logic [sobsq_pkg::GRAD_W-1:0] gx_nxt, gy_nxt, gx_r, gy_r;

  function automatic logic [sobsq_pkg::GRAD_W-1:0] wsum(
    input logic [sobsq_pkg::PIX_W-1:0] a,
    input logic [sobsq_pkg::PIX_W-1:0] b,
    input logic [sobsq_pkg::PIX_W-1:0] c
  );
    return sobsq_pkg::GRAD_W'(a) + (sobsq_pkg::GRAD_W'(b) << 1) + sobsq_pkg::GRAD_W'(c);
  endfunction

  function automatic logic [sobsq_pkg::GRAD_W-1:0] absdiff(
    input logic [sobsq_pkg::GRAD_W-1:0] a,
    input logic [sobsq_pkg::GRAD_W-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Weighted 1-2-1 column and row sums
  assign right  = wsum(lines.top, lines.mid, pixel);
  assign left   = wsum(lt_r, lm_r, lb_r);
  assign upper  = wsum(lt_r, ct_r, lines.top);
  assign lower  = wsum(lb_r, cb_r, pixel);
  assign gx_nxt = absdiff(right, left);
  assign gy_nxt = absdiff(upper, lower);

  // Window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= '0;
      lm_r <= '0;
      lb_r <= '0;
      ct_r <= '0;
      cm_r <= '0;
      cb_r <= '0;
    end else if (shift) begin
      lt_r <= ct_r;
      lm_r <= cm_r;
      lb_r <= cb_r;
      ct_r <= lines.top;
      cm_r <= lines.mid;
      cb_r <= pixel;
    end
  end

  // Gradient register
  always_ff @(posedge clk) begin
    if (shift) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
    end
  end

  assign gx = gx_r;
  assign gy = gy_r;

endmodule

// ===== src/sobsq_mag.sv =====
// ----------------------------------------------------------------------------
// sobsq_mag
// Squares the gradients, sums them, tracks the frame maximum and holds the
// result register.
// ----------------------------------------------------------------------------
module sobsq_mag (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load_sq,
  input  logic [sobsq_pkg::GRAD_W-1:0]  gx,
  input  logic [sobsq_pkg::GRAD_W-1:0]  gy,
  input  logic                          load_out,
  input  sobsq_pkg::flag_t              flags,
  input  logic                          out_ready,
  output logic                          out_valid,
  output sobsq_pkg::out_beat_t          out_data
);

  logic [sobsq_pkg::SQ_W-1:0]  sqx_r, sqy_r;
  logic [sobsq_pkg::MAG_W-1:0] mag, max_r, max_nxt;
  logic                        out_valid_r;
  sobsq_pkg::out_beat_t        out_data_r;

  // Squares
  always_ff @(posedge clk) begin
    if (load_sq) begin
      sqx_r <= sobsq_pkg::SQ_W'(gx) * sobsq_pkg::SQ_W'(gx);
      sqy_r <= sobsq_pkg::SQ_W'(gy) * sobsq_pkg::SQ_W'(gy);
    end
  end

  // Sum and running maximum
  assign mag     = sobsq_pkg::MAG_W'(sqx_r) + sobsq_pkg::MAG_W'(sqy_r);
  assign max_nxt = (mag > max_r) ? mag : max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
    end else if (load_out) begin
      if (flags.sof) begin
        max_r <= '0;
      end else if (flags.has_result) begin
        max_r <= max_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= flags.has_result;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && flags.has_result) begin
      out_data_r.magnitude_sq <= mag;
      out_data_r.frame_max    <= max_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
